FILE: rtl/lfu_pkg.sv
// Shared types and constants for the LFU slot replacement block.
// No dependencies; imported by the controller, datapath and top level.
package lfu_pkg;

  localparam int SLOTS   = 32;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int LEVELS  = IDX_W;
  localparam int LVL_W   = $clog2(LEVELS + 1);
  localparam int ID_W    = 8;
  localparam int COUNT_W = 16;
  localparam int ARR_W   = 32;
  localparam int FC_W    = 6;
  localparam int HELD_W  = IDX_W + 1;
  localparam int MAX_ID  = 255;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [FC_W-1:0]    FC_RESET   = FC_W'(3);
  localparam logic [FC_W-1:0]    SLOTS_FC   = FC_W'(SLOTS);
  localparam logic [HELD_W-1:0]  SLOTS_HELD = HELD_W'(SLOTS);

  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_PLACE   = 2'd1;
  localparam logic [1:0] OUT_REPLACE = 2'd2;
  localparam logic [1:0] OUT_REJECT  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture candidate and arrival number
    logic scan;    // hit/free/held search, seed the victim tree
    logic reduce;  // one level of the victim tree
    logic commit;  // update table and output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] cnt;
    logic [ARR_W-1:0]   arr;
    logic [IDX_W-1:0]   idx;
  } node_t;

endpackage

FILE: rtl/lfu_ctrl.sv
// Sequencer for the LFU slot replacement block: accept, scan, reduce, commit.
// Depends on lfu_pkg.
module lfu_ctrl import lfu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    lvl_nxt    = lvl_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        lvl_nxt   = '0;
        state_nxt = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        lvl_nxt    = lvl_r + 1'b1;
        if (lvl_r == LVL_W'(LEVELS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the previous result has left the output register
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

FILE: rtl/lfu_datapath.sv
// Slot table, arrival counter, victim reduction tree and output register.
// Depends on lfu_pkg; driven by lfu_ctrl commands.
module lfu_datapath import lfu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic [FC_W-1:0]    cfg_frame_count,
  input  logic [ID_W-1:0]    in_candidate_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_outcome,
  output logic [ID_W-1:0]    out_evicted_id,
  output logic [COUNT_W-1:0] out_new_count
);

  logic [FC_W-1:0]    frame_count_r;
  logic [SLOTS-1:0]   valid_r;
  logic [ID_W-1:0]    key_r [SLOTS];
  logic [COUNT_W-1:0] cnt_r [SLOTS];
  logic [ARR_W-1:0]   arr_r [SLOTS];
  logic [ARR_W-1:0]   arrival_r;

  logic [ID_W-1:0]    cand_r;
  logic [ARR_W-1:0]   now_r;
  logic               reject_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [COUNT_W-1:0] hit_cnt_r;
  logic               full_r;
  logic [IDX_W-1:0]   free_idx_r;
  node_t              node_r [SLOTS];

  logic               out_valid_r;
  logic [1:0]         outcome_r;
  logic [ID_W-1:0]    evicted_r;
  logic [COUNT_W-1:0] new_count_r;

  // scan results
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               has_free;
  logic [IDX_W-1:0]   free_idx;
  logic [HELD_W-1:0]  held;
  logic [HELD_W-1:0]  eff_frames;
  logic [COUNT_W-1:0] hit_sat;
  logic [IDX_W-1:0]   victim;

  function automatic node_t pick(node_t a, node_t b);
    node_t res;
    res = a;
    if (!a.ok) begin
      res = b;
    end else if (b.ok && (b.cnt < a.cnt || (b.cnt == a.cnt && b.arr < a.arr))) begin
      res = b;
    end
    return res;
  endfunction

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    held     = '0;
    // descending so the lowest index wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == cand_r) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      held = held + {{IDX_W{1'b0}}, valid_r[i]};
    end
  end

  always_comb begin
    if (frame_count_r == '0) begin
      eff_frames = HELD_W'(1);
    end else if (frame_count_r > SLOTS_FC) begin
      eff_frames = SLOTS_HELD;
    end else begin
      eff_frames = HELD_W'(frame_count_r);
    end
  end

  assign hit_sat = (hit_cnt_r == COUNT_MAX) ? COUNT_MAX : hit_cnt_r + 1'b1;
  assign victim  = full_r ? node_r[0].idx : free_idx_r;

  assign sts.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FC_RESET;
      valid_r       <= '0;
      arrival_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_count_r <= cfg_frame_count;
      end
      if (cmd.load) begin
        arrival_r <= arrival_r + 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit && !reject_r && !hit_r) begin
        valid_r[victim] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_r   <= in_candidate_id;
      now_r    <= arrival_r;
      reject_r <= (in_candidate_id == '0) || (32'(in_candidate_id) > 32'(MAX_ID));
    end
    if (cmd.scan) begin
      hit_r      <= hit;
      hit_idx_r  <= hit_idx;
      hit_cnt_r  <= cnt_r[hit_idx];
      full_r     <= (held >= eff_frames) || !has_free;
      free_idx_r <= free_idx;
      for (int i = 0; i < SLOTS; i++) begin
        node_r[i] <= '{ok: valid_r[i], cnt: cnt_r[i], arr: arr_r[i], idx: IDX_W'(i)};
      end
    end
    if (cmd.reduce) begin
      for (int i = 0; i < SLOTS / 2; i++) begin
        node_r[i] <= pick(node_r[2*i], node_r[2*i+1]);
      end
    end
    if (cmd.commit) begin
      priority if (reject_r) begin
        outcome_r   <= OUT_REJECT;
        evicted_r   <= '0;
        new_count_r <= '0;
      end else if (hit_r) begin
        cnt_r[hit_idx_r] <= hit_sat;
        outcome_r        <= OUT_HIT;
        evicted_r        <= '0;
        new_count_r      <= hit_sat;
      end else begin
        key_r[victim] <= cand_r;
        cnt_r[victim] <= COUNT_W'(1);
        arr_r[victim] <= now_r;
        outcome_r     <= full_r ? OUT_REPLACE : OUT_PLACE;
        evicted_r     <= full_r ? key_r[victim] : '0;
        new_count_r   <= COUNT_W'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = outcome_r;
  assign out_evicted_id = evicted_r;
  assign out_new_count  = new_count_r;

endmodule

FILE: rtl/lfu_slot_replacement_top.sv
// Top level of the LFU slot replacement block (oldest arrival breaks ties).
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_candidate_id[7:0]
//   out      output     out_valid/out_stall  out_outcome[1:0], out_evicted_id[7:0],
//                                            out_new_count[15:0]
//   cfg      input      cfg_we               cfg_frame_count[5:0]
//
// A transaction runs through accept, a scan, the registered victim tree (one level
// per cycle over 32 slots) and a commit.
// A new transaction is accepted while a result still waits on out_stall;
// its commit waits until the output register is free.
// Reset (rst_n low, synchronous) empties the table, zeroes the arrival counter
// and sets frame_count to 3.
module lfu_slot_replacement_top import lfu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FC_W-1:0]    cfg_frame_count,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    in_candidate_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_outcome,
  output logic [ID_W-1:0]    out_evicted_id,
  output logic [COUNT_W-1:0] out_new_count
);

  cmd_t cmd;
  sts_t sts;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfu_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_frame_count (cfg_frame_count),
    .in_candidate_id (in_candidate_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_outcome     (out_outcome),
    .out_evicted_id  (out_evicted_id),
    .out_new_count   (out_new_count)
  );

endmodule
